// ----- src/sbcg_pkg.sv -----
package sbcg_pkg;

  // Default sizing of the per-bin state store
  localparam int DEF_MAX_FFT_SIZE = 16384;
  localparam int DEF_CHANNELS     = 2;

  // Field widths
  localparam int BIN_W    = 14;
  localparam int LEVEL_W  = 16;
  localparam int OCT_W    = 13;
  localparam int THR_W    = 16;
  localparam int SLOPE_W  = 13;
  localparam int RATIO_W  = 16;
  localparam int KNEE_W   = 13;
  localparam int COEF_W   = 16;
  localparam int RED_W    = 16;

  // Stream word widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_LEFT  = 3'd0,
    REG_THRESHOLD_RIGHT = 3'd1,
    REG_SLOPE           = 3'd2,
    REG_RATIO           = 3'd3,
    REG_KNEE            = 3'd4,
    REG_ATTACK          = 3'd5,
    REG_RELEASE         = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [THR_W-1:0]   RST_THRESHOLD = 16'hEC00;  // -20 dB
  localparam logic [SLOPE_W-1:0] RST_SLOPE     = 13'd0;
  localparam logic [RATIO_W-1:0] RST_RATIO     = 16'd32768;
  localparam logic [KNEE_W-1:0]  RST_KNEE      = 13'd1536;
  localparam logic [COEF_W-1:0]  RST_ATTACK    = 16'd60000;
  localparam logic [COEF_W-1:0]  RST_RELEASE   = 16'd65000;

  // Datapath widths
  localparam int TILT_W = SLOPE_W + OCT_W;          // slope * octave
  localparam int D_W    = TILT_W + 2;               // excess in 1/65536 dB, signed
  localparam int H_SH   = 7;                        // half knee = knee * 128
  localparam int P_W    = KNEE_W + H_SH + 1;        // knee excess, below twice the half knee
  localparam int SQ_W   = 2 * P_W;
  localparam int SQH_W  = SQ_W / 2;                 // split of the square for the ratio product
  localparam int MP_W   = RATIO_W + SQH_W;
  localparam int NS_W   = RATIO_W + SQ_W;           // ratio * square
  localparam int DIV_SH = 25;                       // knee << 25 in the divisor
  localparam int NQ_W   = NS_W - DIV_SH;            // dividend after the shift
  localparam int QW     = NQ_W - KNEE_W;            // quotient bits
  localparam int HM_W   = RATIO_W + D_W - 1;        // ratio * positive excess
  localparam int WANT_W = D_W - 1;                  // target reduction in 1/65536 dB
  localparam int ACC_W  = 45;                       // smoothing accumulator
  localparam logic [ACC_W-1:0] ACC_ROUND = 45'h80_0000;

  // Item tag carried along the pipeline
  typedef struct packed {
    logic             ch;
    logic [BIN_W-1:0] bin;
    logic             stored;
  } item_t;

endpackage

// ----- src/spectral_bin_compressor_gain.sv -----
// Channel  | Dir | Handshake                | Contents (lowest bit first)
// s_*      | in  | s_tvalid / s_tready      | tdata: bin_index, level_db, octave_offset; tuser: channel
// m_*      | out | m_tvalid / m_tready      | tdata: out_bin, reduction_db; tuser: out_channel
// cfg_*    | in  | cfg_we (no wait)         | cfg_index selects register, cfg_data is the value
//
// One word per cycle while the output does not stall and the clear is done; the pipeline
// holds the excess and knee registers, the square and ratio product registers, a 20-step
// pipelined restoring divider for the soft knee, the state memory read and the output register.
// After reset the state memory is cleared one entry a cycle, all CHANNELS*(MAX_FFT_SIZE/2+1)
// entries (16386 by default); s_tready stays low meanwhile, configuration writes are taken.
// A stalled output holds the whole pipeline; s_tready follows the output register's room.
// A bin read right after the same bin was written takes the fresh value from a bypass.
module spectral_bin_compressor_gain #(
  parameter int MAX_FFT_SIZE = sbcg_pkg::DEF_MAX_FFT_SIZE,
  parameter int CHANNELS     = sbcg_pkg::DEF_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst,
  // tdata: bin_index[13:0], level_db[29:14], octave_offset[42:30], zero fill
  input  logic [sbcg_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: channel
  input  logic                             s_tuser,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata: out_bin[13:0], reduction_db[29:14], zero fill
  output logic [sbcg_pkg::OUT_DATA_W-1:0]  m_tdata,
  // tuser: out_channel
  output logic                             m_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_we,
  input  logic [sbcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbcg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbcg_pkg::*;

  localparam int BINS  = MAX_FFT_SIZE / 2 + 1;
  localparam int DEPTH = CHANNELS * BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NS    = 5 + QW;   // stages up to the divider's last step

  // Configuration registers
  logic [THR_W-1:0]   thr_left;
  logic [THR_W-1:0]   thr_right;
  logic [SLOPE_W-1:0] slope;
  logic [RATIO_W-1:0] ratio;
  logic [KNEE_W-1:0]  knee;
  logic [COEF_W-1:0]  attack;
  logic [COEF_W-1:0]  release_c;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_left  <= RST_THRESHOLD;
      thr_right <= RST_THRESHOLD;
      slope     <= RST_SLOPE;
      ratio     <= RST_RATIO;
      knee      <= RST_KNEE;
      attack    <= RST_ATTACK;
      release_c <= RST_RELEASE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD_LEFT:  thr_left  <= cfg_data[THR_W-1:0];
        REG_THRESHOLD_RIGHT: thr_right <= cfg_data[THR_W-1:0];
        REG_SLOPE:           slope     <= cfg_data[SLOPE_W-1:0];
        REG_RATIO:           ratio     <= cfg_data[RATIO_W-1:0];
        REG_KNEE:            knee      <= cfg_data[KNEE_W-1:0];
        REG_ATTACK:          attack    <= cfg_data[COEF_W-1:0];
        REG_RELEASE:         release_c <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: whole pipeline moves when the output register has room
  logic adv;
  logic clr_busy;
  logic [AW-1:0] clr_addr;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !clr_busy;

  // Clear the state memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Input word fields
  logic [BIN_W-1:0]   in_bin;
  logic [LEVEL_W-1:0] in_level;
  logic [OCT_W-1:0]   in_oct;
  logic [THR_W-1:0]   in_thr;
  logic [LEVEL_W:0]   in_diff;
  logic [TILT_W-1:0]  in_tilt;
  logic [D_W-1:0]     in_d;
  item_t              in_item;
  logic [AW-1:0]      in_addr;

  assign in_bin   = s_tdata[BIN_W-1:0];
  assign in_level = s_tdata[BIN_W+LEVEL_W-1:BIN_W];
  assign in_oct   = s_tdata[BIN_W+LEVEL_W+OCT_W-1:BIN_W+LEVEL_W];

  // Form the tilted excess and the state address
  always_comb begin
    in_thr  = s_tuser ? thr_right : thr_left;
    in_diff = {in_level[LEVEL_W-1], in_level} - {in_thr[THR_W-1], in_thr};
    in_tilt = TILT_W'(slope) * TILT_W'(in_oct);
    in_d    = {{(D_W-LEVEL_W-9){in_diff[LEVEL_W]}}, in_diff, 8'b0} + {2'b0, in_tilt};
    in_item.ch     = s_tuser;
    in_item.bin    = in_bin;
    in_item.stored = ({31'b0, s_tuser} < CHANNELS) && ({18'b0, in_bin} < BINS);
    in_addr = AW'(in_bin) + (s_tuser ? AW'(BINS) : AW'(0));
  end

  // Pipeline tags and per-stage data
  logic              v   [0:NS-1];
  item_t             it  [0:NS-1];
  logic [AW-1:0]     ad  [0:NS-1];
  logic              sf  [1:NS-1];
  logic [WANT_W-1:0] wh  [1:NS-1];

  logic [D_W-1:0]    d_r;
  logic [P_W-1:0]    p_r;
  logic [SQ_W-1:0]   sq_r;
  logic [MP_W-1:0]   mlo_r;
  logic [MP_W-1:0]   mhi_r;
  logic [KNEE_W-1:0] dr [0:QW];
  logic [QW-1:0]     db [0:QW];
  logic [QW-1:0]     dq [0:QW];

  // Knee decision and hard-knee reduction
  logic [D_W-1:0]    hx;
  logic [D_W-1:0]    p_full;
  logic              ge_h;
  logic              d_pos;
  logic              soft1;
  logic [HM_W-1:0]   hard_prod;
  logic [WANT_W-1:0] want_hard1;

  always_comb begin
    hx        = {{(D_W-KNEE_W-H_SH){1'b0}}, knee, {H_SH{1'b0}}};
    p_full    = d_r + hx;
    ge_h      = $signed(d_r) >= $signed(hx);
    d_pos     = $signed(d_r) > $signed(D_W'(0));
    soft1     = (knee != '0) && !ge_h && ($signed(p_full) > $signed(D_W'(0)));
    hard_prod = HM_W'(ratio) * HM_W'(d_r[WANT_W-1:0]);
    if (((knee == '0) || ge_h) && d_pos) begin
      want_hard1 = hard_prod[HM_W-1:RATIO_W];
    end else begin
      want_hard1 = '0;
    end
  end

  // Combine the split ratio product into the dividend
  logic [NS_W-1:0] nsum;
  assign nsum = {mhi_r, {SQH_W{1'b0}}} + {{SQH_W{1'b0}}, mlo_r};

  // Restoring divider steps by the knee width
  logic [KNEE_W:0] tw [0:QW-1];
  logic [KNEE_W:0] dt [0:QW-1];
  logic            qb [0:QW-1];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      tw[j] = {dr[j], db[j][QW-1]};
      dt[j] = tw[j] - {1'b0, knee};
      qb[j] = tw[j] >= {1'b0, knee};
    end
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        v[i] <= 1'b0;
      end
    end else if (adv) begin
      v[0] <= s_tvalid && s_tready;
      for (int i = 1; i < NS; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it[0] <= in_item;
      ad[0] <= in_addr;
      for (int i = 1; i < NS; i++) begin
        it[i] <= it[i-1];
        ad[i] <= ad[i-1];
      end
      sf[1] <= soft1;
      wh[1] <= want_hard1;
      for (int i = 2; i < NS; i++) begin
        sf[i] <= sf[i-1];
        wh[i] <= wh[i-1];
      end
      // excess, knee offset, square, ratio product
      d_r   <= in_d;
      p_r   <= p_full[P_W-1:0];
      sq_r  <= SQ_W'(p_r) * SQ_W'(p_r);
      mlo_r <= MP_W'(ratio) * MP_W'(sq_r[SQH_W-1:0]);
      mhi_r <= MP_W'(ratio) * MP_W'(sq_r[SQ_W-1:SQH_W]);
      // load the divider: high dividend bits start as the remainder
      dr[0] <= nsum[NS_W-1:NS_W-KNEE_W];
      db[0] <= nsum[DIV_SH+QW-1:DIV_SH];
      dq[0] <= '0;
      for (int j = 0; j < QW; j++) begin
        dr[j+1] <= qb[j] ? dt[j][KNEE_W-1:0] : tw[j][KNEE_W-1:0];
        db[j+1] <= {db[j][QW-2:0], 1'b0};
        dq[j+1] <= {dq[j][QW-2:0], qb[j]};
      end
    end
  end

  // Target reduction at the divider's last step
  logic [WANT_W-1:0] want_last;
  assign want_last = sf[NS-1] ? {{(WANT_W-QW){1'b0}}, dq[QW]} : wh[NS-1];

  // Smoothing stage with the state memory
  logic [RED_W-1:0]  mem [0:DEPTH-1];
  logic [RED_W-1:0]  rd;
  logic              s_v;
  item_t             s_it;
  logic [AW-1:0]     s_addr;
  logic [WANT_W-1:0] s_want;
  logic              f_v;
  logic [AW-1:0]     f_addr;
  logic [RED_W-1:0]  f_data;

  logic [RED_W-1:0]    prev;
  logic [RED_W+7:0]    prev8;
  logic [COEF_W-1:0]   coef;
  logic [COEF_W:0]     coef_inv;
  logic [2*COEF_W-1:0] hold_prod;
  logic [ACC_W-1:0]    acc;
  logic [RED_W-1:0]    nxt;

  always_comb begin
    if (!s_it.stored) begin
      prev = '0;
    end else if (f_v && (f_addr == s_addr)) begin
      prev = f_data;
    end else begin
      prev = rd;
    end
    prev8     = {prev, 8'b0};
    coef      = (WANT_W'(prev8) < s_want) ? attack : release_c;
    coef_inv  = 17'h1_0000 - {1'b0, coef};
    hold_prod = (2*COEF_W)'(coef) * (2*COEF_W)'(prev);
    acc       = {{(ACC_W-2*COEF_W-8){1'b0}}, hold_prod, 8'b0}
              + ACC_W'(coef_inv) * ACC_W'(s_want) + ACC_ROUND;
    nxt       = (|acc[ACC_W-1:RED_W+24]) ? {RED_W{1'b1}} : acc[RED_W+23:24];
  end

  // Read ahead, write back, clear
  always_ff @(posedge clk) begin
    if (adv) begin
      rd <= mem[ad[NS-1]];
    end
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (adv && s_v && s_it.stored) begin
      mem[s_addr] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v      <= 1'b0;
      f_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s_v      <= v[NS-1];
      f_v      <= s_v && s_it.stored;
      m_tvalid <= s_v;
    end
  end

  // Hold stage payload and bypass value
  always_ff @(posedge clk) begin
    if (adv) begin
      s_it    <= it[NS-1];
      s_addr  <= ad[NS-1];
      s_want  <= want_last;
      f_addr  <= s_addr;
      f_data  <= nxt;
      m_tuser <= s_it.ch;
      m_tdata <= {{(OUT_DATA_W-BIN_W-RED_W){1'b0}}, nxt, s_it.bin};
    end
  end

endmodule

// ----- tb/sbcg_gain_checker.sv -----
module sbcg_gain_checker (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: bin_index, level_db, octave_offset, zero fill
  input  logic [sbcg_pkg::IN_DATA_W-1:0]  s_tdata,
  // tuser: channel
  input  logic                            s_tuser,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // tdata: out_bin, reduction_db, zero fill
  input  logic [sbcg_pkg::OUT_DATA_W-1:0] m_tdata,
  // tuser: out_channel
  input  logic                            m_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [sbcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbcg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import sbcg_pkg::*;

  localparam int BINS       = DEF_MAX_FFT_SIZE / 2 + 1;
  localparam int CH_N       = DEF_CHANNELS;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic             ch;
    logic [BIN_W-1:0] bin;
    logic [RED_W-1:0] red;
  } gain_word_t;

  // Words still owed by the block, oldest first
  gain_word_t pending_gains[$];
  gain_word_t seen_word;
  gain_word_t owed_word;

  // Smoothed reduction per channel and bin
  logic [RED_W-1:0] bin_reduction [CH_N*BINS];

  logic signed [THR_W-1:0] thr_left;
  logic signed [THR_W-1:0] thr_right;
  logic [SLOPE_W-1:0]      slope;
  logic [RATIO_W-1:0]      ratio;
  logic [KNEE_W-1:0]       knee;
  logic [COEF_W-1:0]       atk_coef;
  logic [COEF_W-1:0]       rel_coef;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Target reduction in 1/65536 dB for an excess over the tilted threshold
  function automatic logic [63:0] knee_target(longint excess);
    longint      half;
    logic [63:0] span;
    half = longint'(knee) * 128;
    if (knee == '0 || excess >= half) begin
      if (excess <= 0) return 64'd0;
      span = 64'(excess);
      return (64'(ratio) * span) >> 16;
    end
    if (excess <= -half) return 64'd0;
    span = 64'(excess + half);
    return (64'(ratio) * span * span) / (64'(knee) << 25);
  endfunction

  // Smooth the target against the stored value, update the store, form the word
  function automatic gain_word_t predict_gain(logic ch, logic [BIN_W-1:0] bin,
                                              logic [LEVEL_W-1:0] level,
                                              logic [OCT_W-1:0] oct);
    int          slot;
    logic        keep;
    logic [63:0] prev_q;
    longint      excess;
    logic [63:0] want;
    logic [63:0] coef;
    logic [63:0] acc;
    logic [63:0] nxt;
    gain_word_t  w;
    keep   = (int'(bin) < BINS);
    slot   = int'(ch) * BINS + int'(bin);
    prev_q = 64'd0;
    if (keep) prev_q = 64'(bin_reduction[slot]) << 8;
    excess = 256 * longint'($signed(level))
           - 256 * longint'(ch ? thr_right : thr_left)
           + longint'(slope) * longint'(oct);
    want = knee_target(excess);
    coef = (want > prev_q) ? 64'(atk_coef) : 64'(rel_coef);
    acc  = coef * prev_q + (64'd65536 - coef) * want + 64'h80_0000;
    nxt  = acc >> 24;
    if (nxt > 64'hFFFF) nxt = 64'hFFFF;
    if (keep) bin_reduction[slot] = nxt[RED_W-1:0];
    w.ch  = ch;
    w.bin = bin;
    w.red = nxt[RED_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      thr_left  = RST_THRESHOLD;
      thr_right = RST_THRESHOLD;
      slope     = RST_SLOPE;
      ratio     = RST_RATIO;
      knee      = RST_KNEE;
      atk_coef  = RST_ATTACK;
      rel_coef  = RST_RELEASE;
      for (int i = 0; i < CH_N * BINS; i++) bin_reduction[i] = '0;
      pending_gains.delete();
      outstanding = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD_LEFT:  thr_left  = cfg_data;
          REG_THRESHOLD_RIGHT: thr_right = cfg_data;
          REG_SLOPE:           slope     = cfg_data[SLOPE_W-1:0];
          REG_RATIO:           ratio     = cfg_data[RATIO_W-1:0];
          REG_KNEE:            knee      = cfg_data[KNEE_W-1:0];
          REG_ATTACK:          atk_coef  = cfg_data[COEF_W-1:0];
          REG_RELEASE:         rel_coef  = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end

      // Predict on every accepted input word
      if (s_tvalid && s_tready)
        pending_gains.push_back(predict_gain(s_tuser, s_tdata[13:0], s_tdata[29:14],
                                             s_tdata[42:30]));

      // Compare every accepted output word with the oldest prediction
      if (m_tvalid && m_tready) begin
        seen_word.ch  = m_tuser;
        seen_word.bin = m_tdata[13:0];
        seen_word.red = m_tdata[29:14];
        if (pending_gains.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected word: ch %0d bin %0d reduction %0d",
                     seen_word.ch, seen_word.bin, seen_word.red);
        end else begin
          owed_word = pending_gains.pop_front();
          if (seen_word != owed_word) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"word mismatch: expected ch %0d bin %0d reduction %0d, ",
                        "got ch %0d bin %0d reduction %0d"},
                       owed_word.ch, owed_word.bin, owed_word.red,
                       seen_word.ch, seen_word.bin, seen_word.red);
          end
        end
      end
      outstanding = pending_gains.size();
    end
  end

endmodule

// ----- tb/tb_spectral_bin_compressor_gain.sv -----
module tb_spectral_bin_compressor_gain;
  import sbcg_pkg::*;

  localparam int STALL_LIMIT = 70000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatches;
  int outstanding;
  int src_idle_pct  = 29;
  int sink_idle_pct = 29;
  int quiet_cycles  = 0;
  int thr_now [2]   = '{-5120, -5120};
  int last_ch       = 0;
  int last_bin      = 0;

  spectral_bin_compressor_gain DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sbcg_gain_checker gain_check (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the output side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one bin word after a random gap and hold it until taken
  task automatic push_bin(input int ch, input int bin, input int level, input int oct);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ch[0];
    s_tdata  <= {5'b0, oct[OCT_W-1:0], level[LEVEL_W-1:0], bin[BIN_W-1:0]};
    last_ch  = ch;
    last_bin = bin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hold off input until every predicted word has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int thr_l, input int thr_r, input int slope,
                               input int ratio, input int knee, input int atk,
                               input int rel);
    write_reg(REG_THRESHOLD_LEFT, thr_l);
    write_reg(REG_THRESHOLD_RIGHT, thr_r);
    write_reg(REG_SLOPE, slope);
    write_reg(REG_RATIO, ratio);
    write_reg(REG_KNEE, knee);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    thr_now[0] = thr_l;
    thr_now[1] = thr_r;
  endtask

  // Mostly a few hot bins, with levels near the threshold or across the usual range, some raw noise
  task automatic random_bin();
    int mode;
    int ch;
    int bin;
    int level;
    int oct;
    mode = $urandom_range(99);
    ch   = $urandom_range(1);
    if (mode < 10) begin
      ch  = last_ch;
      bin = last_bin;
    end else if (mode < 80) begin
      bin = ($urandom_range(3) == 0) ? 8193 - $urandom_range(3) : $urandom_range(15);
    end else begin
      bin = $urandom_range(16383);
    end
    if (mode >= 80) begin
      level = $urandom_range(65535);
      oct   = $urandom_range(8191);
    end else if ($urandom_range(1) == 1) begin
      level = thr_now[ch] + int'($urandom_range(6000)) - 3000;
      oct   = $urandom_range(256);
    end else begin
      level = -30720 + int'($urandom_range(36864));
      oct   = $urandom_range(4096);
    end
    push_bin(ch, bin, level, oct);
  endtask

  task automatic run_phase(input int count);
    repeat (count) begin
      random_bin();
      if ($urandom_range(199) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Default setting: attack then release on one bin, range edges, knee edges
    push_bin(0, 0, 6144, 0);
    push_bin(0, 0, 6144, 0);
    push_bin(0, 0, -30720, 0);
    push_bin(1, 8192, 32767, 8191);
    push_bin(1, 8192, -32768, 0);
    push_bin(0, 8193, 6144, 0);
    push_bin(1, 16383, 0, 4096);
    push_bin(0, 1, -5120, 0);
    push_bin(0, 2, -4352, 0);
    push_bin(0, 3, -5888, 0);
    push_bin(0, 4, -5000, 0);
    push_bin(1, 5, -4000, 4096);
    run_phase(150);

    // Hard knee, level right at and just around the threshold
    apply_setting(-5120, -2560, 0, 49152, 0, 30000, 60000);
    push_bin(0, 10, -5120, 0);
    push_bin(0, 10, -5119, 0);
    push_bin(1, 11, -2560, 0);
    push_bin(1, 11, -2561, 0);
    run_phase(150);

    // Range extremes with a stretch of back-to-back traffic
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    apply_setting(-30720, 0, 6144, 65535, 6144, 0, 0);
    run_phase(150);
    src_idle_pct  = 29;
    sink_idle_pct = 29;

    // Full register bit patterns and a write to an unmapped index
    apply_setting(32767, -32768, 8191, 0, 8191, 65535, 65535);
    write_reg(REG_UNMAPPED, 16'h5A5A);
    run_phase(150);

    apply_setting(0, -30720, 1, 65535, 1, 65535, 0);
    run_phase(150);

    // Random settings inside the usual ranges
    repeat (4) begin
      apply_setting(-int'($urandom_range(30720)), -int'($urandom_range(30720)),
                    $urandom_range(6144), $urandom_range(65535),
                    ($urandom_range(3) == 0) ? 0 : $urandom_range(6144),
                    $urandom_range(65535), $urandom_range(65535));
      run_phase(150);
    end

    apply_setting(-5120, -5120, 0, 32768, 1536, 60000, 65000);
    run_phase(150);

    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
